// ===== rtl/csls_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes and keyword table for the C-subset lexical scanner.
// Used by csls_front, csls_back and c_subset_lexical_scanner; depends on nothing.
package csls_pkg;

    localparam int NUM_KEYWORDS = 12;
    localparam int QUEUE_DEPTH  = 2;

    // Token classes
    localparam logic [2:0] TK_KEYWORD    = 3'd0;
    localparam logic [2:0] TK_IDENTIFIER = 3'd1;
    localparam logic [2:0] TK_INTEGER    = 3'd2;
    localparam logic [2:0] TK_FLOAT      = 3'd3;
    localparam logic [2:0] TK_ARITH      = 3'd4;
    localparam logic [2:0] TK_RELATIONAL = 3'd5;
    localparam logic [2:0] TK_ASSIGN     = 3'd6;
    localparam logic [2:0] TK_PUNCT      = 3'd7;

    // Character codes
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    typedef enum logic [3:0] {
        BC_SPACE,
        BC_NEWLINE,
        BC_SLASH,
        BC_STAR,
        BC_EQUALS,
        BC_REL,
        BC_ALPHA,
        BC_DIGIT,
        BC_DOT,
        BC_ARITH,
        BC_OTHER
    } t_byte_class;

    typedef enum logic [3:0] {
        SM_IDLE,
        SM_WORD,
        SM_NUM,
        SM_SLASH,
        SM_EQ,
        SM_REL,
        SM_LINE,
        SM_BLOCK,
        SM_STAR
    } t_scan_mode;

    typedef struct packed {
        logic [7:0]  data;
        t_byte_class cls;
        logic        eos;
    } t_item;

    typedef struct packed {
        logic [2:0]  cls;
        logic [7:0]  op;
        logic        weq;
        logic [6:0]  len;
        logic [3:0]  kw;
        logic [31:0] start;
        logic        too_long;
        logic        last;
    } t_token;

    function automatic logic [3:0] kw_len(input logic [3:0] k);
        logic [3:0] n;
        case (k)
            4'd0:    n = 4'd3;
            4'd1:    n = 4'd5;
            4'd2:    n = 4'd6;
            4'd3:    n = 4'd4;
            4'd4:    n = 4'd2;
            4'd5:    n = 4'd4;
            4'd6:    n = 4'd3;
            4'd7:    n = 4'd5;
            4'd8:    n = 4'd6;
            4'd9:    n = 4'd5;
            4'd10:   n = 4'd8;
            4'd11:   n = 4'd4;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // Keyword text, right aligned: the last character sits in the low byte
    function automatic logic [63:0] kw_text(input logic [3:0] k);
        logic [63:0] t;
        case (k)
            4'd0:    t = "int";
            4'd1:    t = "float";
            4'd2:    t = "double";
            4'd3:    t = "char";
            4'd4:    t = "if";
            4'd5:    t = "else";
            4'd6:    t = "for";
            4'd7:    t = "while";
            4'd8:    t = "return";
            4'd9:    t = "break";
            4'd10:   t = "continue";
            4'd11:   t = "void";
            default: t = 64'h0;
        endcase
        return t;
    endfunction

    // Character at position i of keyword k, zero past its end
    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] i);
        logic [63:0] text;
        logic [3:0]  len;
        logic [3:0]  back;
        logic [7:0]  ch;
        text = kw_text(k);
        len  = kw_len(k);
        ch   = 8'h00;
        back = 4'd0;
        if ({1'b0, i} < len) begin
            back = len - 4'd1 - {1'b0, i};
            ch   = text[{back[2:0], 3'b000} +: 8];
        end
        return ch;
    endfunction

endpackage

// ===== rtl/csls_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts source bytes, classifies each one and queues it for the scanner.
// Depends on csls_pkg.
module csls_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_source_byte,
    input  logic                 i_end_of_stream,
    output logic                 o_item_valid,
    output csls_pkg::t_item      o_item,
    input  logic                 i_item_pop
);

    localparam int PTR_W = (csls_pkg::QUEUE_DEPTH > 1) ? $clog2(csls_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(csls_pkg::QUEUE_DEPTH + 1);

    csls_pkg::t_item r_queue [csls_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_fill, n_fill;
    csls_pkg::t_item  class_item;
    logic             push;
    logic             pop;

    // Classify the incoming byte
    always_comb begin
        class_item.data = i_source_byte;
        class_item.eos  = i_end_of_stream;
        if (i_source_byte == csls_pkg::CH_NEWLINE) begin
            class_item.cls = csls_pkg::BC_NEWLINE;
        end else if (i_source_byte == csls_pkg::CH_SPACE ||
                     (i_source_byte >= csls_pkg::CH_TAB && i_source_byte <= csls_pkg::CH_CR)) begin
            class_item.cls = csls_pkg::BC_SPACE;
        end else if (i_source_byte == csls_pkg::CH_SLASH) begin
            class_item.cls = csls_pkg::BC_SLASH;
        end else if (i_source_byte == csls_pkg::CH_STAR) begin
            class_item.cls = csls_pkg::BC_STAR;
        end else if (i_source_byte == csls_pkg::CH_EQUALS) begin
            class_item.cls = csls_pkg::BC_EQUALS;
        end else if (i_source_byte == csls_pkg::CH_LESS ||
                     i_source_byte == csls_pkg::CH_GREATER) begin
            class_item.cls = csls_pkg::BC_REL;
        end else if ((i_source_byte >= csls_pkg::CH_LOWER_A &&
                      i_source_byte <= csls_pkg::CH_LOWER_Z) ||
                     (i_source_byte >= csls_pkg::CH_UPPER_A &&
                      i_source_byte <= csls_pkg::CH_UPPER_Z) ||
                     i_source_byte == csls_pkg::CH_UNDERSCORE) begin
            class_item.cls = csls_pkg::BC_ALPHA;
        end else if (i_source_byte >= csls_pkg::CH_ZERO &&
                     i_source_byte <= csls_pkg::CH_NINE) begin
            class_item.cls = csls_pkg::BC_DIGIT;
        end else if (i_source_byte == csls_pkg::CH_DOT) begin
            class_item.cls = csls_pkg::BC_DOT;
        end else if (i_source_byte == csls_pkg::CH_PLUS ||
                     i_source_byte == csls_pkg::CH_MINUS ||
                     i_source_byte == csls_pkg::CH_PERCENT) begin
            class_item.cls = csls_pkg::BC_ARITH;
        end else begin
            class_item.cls = csls_pkg::BC_OTHER;
        end
    end

    assign o_ready      = (r_fill != CNT_W'(csls_pkg::QUEUE_DEPTH));
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_fill != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_queue[r_rd_ptr];

    // Advance queue pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(csls_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(csls_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Store the classified item
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= class_item;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(csls_pkg::QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_pop |-> r_fill != '0)
        else $error("scanner popped an empty queue");

endmodule

// ===== rtl/csls_back.sv =====
`timescale 1ns / 1ps
// Back end: the scanner state machine, keyword matcher and two-slot token output.
// Depends on csls_pkg; fed by csls_front.
module csls_back #(
    parameter int LENGTH_LIMIT  = 64,
    parameter int POSITION_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  csls_pkg::t_item      i_item,
    output logic                 o_item_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output csls_pkg::t_token     o_token
);

    localparam int CW  = $clog2(LENGTH_LIMIT + 1);
    localparam int LW  = (CW > 7) ? CW : 7;
    localparam int PW  = POSITION_BITS;
    localparam int SW  = (PW > 32) ? PW : 32;
    localparam int NKW = csls_pkg::NUM_KEYWORDS;

    // Scanner state
    csls_pkg::t_scan_mode r_mode, n_mode;
    logic [7:0]           r_held, n_held;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_point, n_point;
    logic [NKW-1:0]       r_cand, n_cand;
    logic                 r_ovf, n_ovf;
    logic [PW-1:0]        r_start, n_start;
    logic [PW-1:0]        r_pos, n_pos;

    // Output slots
    logic                 r_out_valid, n_out_valid;
    csls_pkg::t_token     r_out, n_out;
    logic                 r_sec_valid, n_sec_valid;
    csls_pkg::t_token     r_sec, n_sec;

    logic                 out_free;
    logic                 pop;
    logic                 do_flush, do_fresh, do_extend, do_releq;
    logic                 begin_run;
    logic                 flush_v, fresh_v;
    csls_pkg::t_token     flush_tok, fresh_tok, releq_tok;
    logic                 t0_v, t1_v;
    csls_pkg::t_token     t0, t1;
    logic                 kw_hit;
    logic [3:0]           kw_idx;
    logic [NKW-1:0]       ext_base;
    logic [CW-1:0]        ext_count;
    logic [NKW-1:0]       cand_ext;
    logic [LW-1:0]        len_wide;
    logic [SW-1:0]        start_wide;
    logic [SW-1:0]        pos_wide;

    assign out_free   = !r_out_valid || i_ready;
    assign pop        = i_item_valid && !r_sec_valid && out_free;
    assign o_item_pop = pop;
    assign o_valid    = r_out_valid;
    assign o_token    = r_out;

    assign len_wide   = LW'(r_count);
    assign start_wide = SW'(r_start);
    assign pos_wide   = SW'(r_pos);

    // Next scan mode and the actions taken for this item
    always_comb begin
        n_mode    = r_mode;
        do_flush  = 1'b0;
        do_fresh  = 1'b0;
        do_extend = 1'b0;
        do_releq  = 1'b0;
        if (i_item.eos) begin
            do_flush = 1'b1;
            n_mode   = csls_pkg::SM_IDLE;
        end else begin
            case (r_mode)
                csls_pkg::SM_WORD: begin
                    if (i_item.cls == csls_pkg::BC_ALPHA || i_item.cls == csls_pkg::BC_DIGIT) begin
                        do_extend = 1'b1;
                    end else begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                csls_pkg::SM_NUM: begin
                    if (i_item.cls == csls_pkg::BC_DIGIT || i_item.cls == csls_pkg::BC_DOT) begin
                        do_extend = 1'b1;
                    end else begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                csls_pkg::SM_SLASH: begin
                    if (i_item.cls == csls_pkg::BC_SLASH) begin
                        n_mode = csls_pkg::SM_LINE;
                    end else if (i_item.cls == csls_pkg::BC_STAR) begin
                        n_mode = csls_pkg::SM_BLOCK;
                    end else begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                csls_pkg::SM_EQ, csls_pkg::SM_REL: begin
                    if (i_item.cls == csls_pkg::BC_EQUALS) begin
                        do_releq = 1'b1;
                        n_mode   = csls_pkg::SM_IDLE;
                    end else begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                csls_pkg::SM_LINE: begin
                    if (i_item.cls == csls_pkg::BC_NEWLINE) begin
                        n_mode = csls_pkg::SM_IDLE;
                    end
                end
                csls_pkg::SM_BLOCK: begin
                    if (i_item.cls == csls_pkg::BC_STAR) begin
                        n_mode = csls_pkg::SM_STAR;
                    end
                end
                csls_pkg::SM_STAR: begin
                    if (i_item.cls == csls_pkg::BC_SLASH) begin
                        n_mode = csls_pkg::SM_IDLE;
                    end else if (i_item.cls != csls_pkg::BC_STAR) begin
                        n_mode = csls_pkg::SM_BLOCK;
                    end
                end
                default: begin
                    do_fresh = 1'b1;
                end
            endcase
            // A fresh byte picks the mode by its class
            if (do_fresh) begin
                case (i_item.cls)
                    csls_pkg::BC_SLASH:  n_mode = csls_pkg::SM_SLASH;
                    csls_pkg::BC_EQUALS: n_mode = csls_pkg::SM_EQ;
                    csls_pkg::BC_REL:    n_mode = csls_pkg::SM_REL;
                    csls_pkg::BC_ALPHA:  n_mode = csls_pkg::SM_WORD;
                    csls_pkg::BC_DIGIT:  n_mode = csls_pkg::SM_NUM;
                    default:             n_mode = csls_pkg::SM_IDLE;
                endcase
            end
        end
    end

    assign begin_run = do_fresh &&
                       (i_item.cls == csls_pkg::BC_ALPHA || i_item.cls == csls_pkg::BC_DIGIT);

    // Narrow the keyword candidates by one more character
    always_comb begin
        ext_base  = begin_run ? '1 : r_cand;
        ext_count = begin_run ? '0 : r_count;
        for (int k = 0; k < NKW; k++) begin
            cand_ext[k] = ext_base[k] &&
                          (ext_count < CW'(csls_pkg::kw_len(4'(k)))) &&
                          (csls_pkg::kw_char(4'(k), ext_count[2:0]) == i_item.data);
        end
    end

    // Build the tokens this item can give
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = 4'd0;
        for (int k = NKW - 1; k >= 0; k--) begin
            if (r_cand[k] && !r_ovf && CW'(csls_pkg::kw_len(4'(k))) == r_count) begin
                kw_hit = 1'b1;
                kw_idx = 4'(k);
            end
        end

        flush_v            = 1'b0;
        flush_tok.cls      = csls_pkg::TK_IDENTIFIER;
        flush_tok.op       = 8'h00;
        flush_tok.weq      = 1'b0;
        flush_tok.len      = 7'd1;
        flush_tok.kw       = 4'd0;
        flush_tok.start    = start_wide[31:0];
        flush_tok.too_long = 1'b0;
        flush_tok.last     = 1'b1;
        case (r_mode)
            csls_pkg::SM_WORD: begin
                flush_v            = 1'b1;
                flush_tok.len      = len_wide[6:0];
                flush_tok.cls      = kw_hit ? csls_pkg::TK_KEYWORD : csls_pkg::TK_IDENTIFIER;
                flush_tok.kw       = kw_hit ? kw_idx : 4'd0;
                flush_tok.too_long = kw_hit ? 1'b0 : r_ovf;
            end
            csls_pkg::SM_NUM: begin
                flush_v            = 1'b1;
                flush_tok.len      = len_wide[6:0];
                flush_tok.cls      = r_point ? csls_pkg::TK_FLOAT : csls_pkg::TK_INTEGER;
                flush_tok.too_long = r_ovf;
            end
            csls_pkg::SM_SLASH: begin
                flush_v       = 1'b1;
                flush_tok.cls = csls_pkg::TK_ARITH;
                flush_tok.op  = csls_pkg::CH_SLASH;
            end
            csls_pkg::SM_EQ: begin
                flush_v       = 1'b1;
                flush_tok.cls = csls_pkg::TK_ASSIGN;
                flush_tok.op  = csls_pkg::CH_EQUALS;
            end
            csls_pkg::SM_REL: begin
                flush_v       = 1'b1;
                flush_tok.cls = csls_pkg::TK_RELATIONAL;
                flush_tok.op  = r_held;
            end
            default: begin
                flush_v = 1'b0;
            end
        endcase

        fresh_v = (i_item.cls == csls_pkg::BC_ARITH) || (i_item.cls == csls_pkg::BC_STAR) ||
                  (i_item.cls == csls_pkg::BC_DOT) || (i_item.cls == csls_pkg::BC_OTHER);
        fresh_tok.cls      = (i_item.cls == csls_pkg::BC_ARITH || i_item.cls == csls_pkg::BC_STAR)
                             ? csls_pkg::TK_ARITH : csls_pkg::TK_PUNCT;
        fresh_tok.op       = i_item.data;
        fresh_tok.weq      = 1'b0;
        fresh_tok.len      = 7'd1;
        fresh_tok.kw       = 4'd0;
        fresh_tok.start    = pos_wide[31:0];
        fresh_tok.too_long = 1'b0;
        fresh_tok.last     = 1'b1;

        releq_tok.cls      = csls_pkg::TK_RELATIONAL;
        releq_tok.op       = r_held;
        releq_tok.weq      = 1'b1;
        releq_tok.len      = 7'd2;
        releq_tok.kw       = 4'd0;
        releq_tok.start    = start_wide[31:0];
        releq_tok.too_long = 1'b0;
        releq_tok.last     = 1'b1;

        // Order: pending token first, then the token of the new byte
        if (do_releq) begin
            t0_v = 1'b1;
            t0   = releq_tok;
            t1_v = 1'b0;
        end else begin
            t0_v = (do_flush && flush_v) || (do_fresh && fresh_v);
            t0   = (do_flush && flush_v) ? flush_tok : fresh_tok;
            t1_v = do_flush && flush_v && do_fresh && fresh_v;
        end
        t1      = fresh_tok;
        t0.last = !t1_v;
    end

    // Next scanner data
    always_comb begin
        n_held  = r_held;
        n_count = r_count;
        n_point = r_point;
        n_cand  = r_cand;
        n_ovf   = r_ovf;
        n_start = r_start;
        n_pos   = r_pos + 1'b1;
        if (i_item.eos) begin
            n_held = 8'h00;
            n_pos  = '0;
        end else if (do_releq) begin
            n_held = 8'h00;
        end else if (do_fresh) begin
            n_held = 8'h00;
            if (i_item.cls == csls_pkg::BC_SLASH || i_item.cls == csls_pkg::BC_EQUALS ||
                i_item.cls == csls_pkg::BC_REL) begin
                n_held  = i_item.data;
                n_start = r_pos;
            end
            if (begin_run) begin
                n_start = r_pos;
                n_count = CW'(1);
                n_point = 1'b0;
                n_ovf   = 1'b0;
                n_cand  = cand_ext;
            end
        end else if (do_extend) begin
            n_cand = cand_ext;
            if (i_item.cls == csls_pkg::BC_DOT) begin
                n_point = 1'b1;
            end
            if (r_count >= CW'(LENGTH_LIMIT)) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    // Next output slots: the second token waits behind the first
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_sec_valid = r_sec_valid;
        n_sec       = r_sec;
        if (out_free) begin
            if (r_sec_valid) begin
                n_out_valid = 1'b1;
                n_out       = r_sec;
                n_sec_valid = 1'b0;
            end else if (pop && t0_v) begin
                n_out_valid = 1'b1;
                n_out       = t0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (pop && t1_v) begin
            n_sec_valid = 1'b1;
            n_sec       = t1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= csls_pkg::SM_IDLE;
            r_held      <= 8'h00;
            r_count     <= '0;
            r_point     <= 1'b0;
            r_cand      <= '0;
            r_ovf       <= 1'b0;
            r_start     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_sec_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_mode  <= n_mode;
                r_held  <= n_held;
                r_count <= n_count;
                r_point <= n_point;
                r_cand  <= n_cand;
                r_ovf   <= n_ovf;
                r_start <= n_start;
                r_pos   <= n_pos;
            end
            r_out_valid <= n_out_valid;
            r_sec_valid <= n_sec_valid;
        end
    end

    // Hold token payloads
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_sec <= n_sec;
    end

    a_sec_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec_valid |-> r_out_valid)
        else $error("second token slot full while output slot empty");

    a_no_pop_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_pop |-> !r_sec_valid)
        else $error("item taken while a second token waits");

    a_eos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item_pop && i_item.eos) |=> (r_pos == '0 && r_mode == csls_pkg::SM_IDLE))
        else $error("end marker did not restart the scanner");

endmodule

// ===== rtl/c_subset_lexical_scanner.sv =====
`timescale 1ns / 1ps
// Lexical scanner for a small C subset: top level joining front end and scanner back end.
// Depends on csls_pkg, csls_front and csls_back.
//
// Feed one source byte per item, with i_end_of_stream set on a final item to flush any
// pending token and restart the stream offset at zero. The scanner takes one item per clock
// when the token side keeps up and no second token waits: a two-entry queue parts the byte
// classifier from the scanner state machine, and the result side has an output register plus
// one waiting slot. A byte that ends a pending token and also forms a token of its own gives
// two tokens, which leave one after the other; while the second waits, no item is taken. An
// accepted byte is registered in the queue and then in the output register before its first
// token shows. Words and numbers longer than LENGTH_LIMIT report a saturated length and raise
// o_too_long. There is no clearing pass after reset.
module c_subset_lexical_scanner #(
    parameter int LENGTH_LIMIT  = 64,
    parameter int POSITION_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_source_byte,
    input  logic        i_end_of_stream,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_token_class,
    output logic [7:0]  o_operator_byte,
    output logic        o_with_equals,
    output logic [6:0]  o_lexeme_length,
    output logic [3:0]  o_keyword_index,
    output logic [31:0] o_start_offset,
    output logic        o_too_long,
    output logic        o_last_of_run
);

    logic              item_valid;
    csls_pkg::t_item   item;
    logic              item_pop;
    csls_pkg::t_token  token;

    csls_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_source_byte   (i_source_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_item_valid    (item_valid),
        .o_item          (item),
        .i_item_pop      (item_pop)
    );

    csls_back #(
        .LENGTH_LIMIT  (LENGTH_LIMIT),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_token      (token)
    );

    // Unpack the token onto its ports
    assign o_token_class   = token.cls;
    assign o_operator_byte = token.op;
    assign o_with_equals   = token.weq;
    assign o_lexeme_length = token.len;
    assign o_keyword_index = token.kw;
    assign o_start_offset  = token.start;
    assign o_too_long      = token.too_long;
    assign o_last_of_run   = token.last;

endmodule
